// ----- rtl/ght_pkg.sv -----
// shared types, constants and codes for the generational handle table
package ght_pkg;

    localparam int SLOTS    = 32;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int REF_BITS = 16;
    localparam int GEN_W    = 32;
    localparam int TYPE_W   = 4;
    localparam int CD_W     = 5;
    localparam int FIF_W    = 4;
    localparam int GUID_W   = 64;

    localparam logic [CD_W-1:0]     CD_DISARMED = '1;
    localparam logic [REF_BITS-1:0] REF_MAX     = '1;
    localparam logic [FIF_W-1:0]    FIF_RESET   = 4'd2;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_REUSE   = 3'd2;
    localparam logic [2:0] CMD_RESOLVE = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_ZERO_REF  = 3'd3;
    localparam logic [2:0] ST_FREED     = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;
    localparam logic [2:0] ST_SATURATED = 3'd6;

    typedef struct packed {
        logic                live;
        logic [TYPE_W-1:0]   kind;
        logic [GEN_W-1:0]    gen;
        logic [REF_BITS-1:0] refs;
        logic [CD_W-1:0]     cd;
    } rec_t;

    localparam rec_t REC_RESET = '{live: 1'b0, kind: '0, gen: 32'd1, refs: '0,
                                   cd: CD_DISARMED};

endpackage

// ----- rtl/ght_ram.sv -----
// generic single write port, single read port memory with registered read data
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/generational_handle_table.sv -----
// top level of the generational handle table: control sequencer and slot memories
//
// Handle requests (create, release, reuse, resolve) read the slot record memory
// (S_RD), then check and write back (S_EX), where the result is registered. A create
// that recycles a slot first reads the free stack memory (S_POP). The result is then
// held until the receiver takes it. A full table, a tick on an empty table and an
// unknown command answer in the cycle after the accept. The input stays stalled until
// the final result of a request is taken. A frame tick walks every slot ever used,
// each with a record read, then an update. Each freed slot result except the final
// one waits for the receiver. Results of a tick come one per freed slot, with last on
// the final one, or a single none-freed result. One request is in work at a time.
module generational_handle_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic [ght_pkg::IDX_W-1:0]      slot_index,
    input  logic [ght_pkg::GEN_W-1:0]      handle_generation,
    input  logic [ght_pkg::TYPE_W-1:0]     type_code,
    input  logic [ght_pkg::TYPE_W-1:0]     expected_type,
    input  logic [ght_pkg::GUID_W-1:0]     guid_high,
    input  logic [ght_pkg::GUID_W-1:0]     guid_low,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [ght_pkg::IDX_W-1:0]      out_index,
    output logic [ght_pkg::GEN_W-1:0]      out_generation,
    output logic [ght_pkg::TYPE_W-1:0]     out_type,
    output logic [ght_pkg::GUID_W-1:0]     out_guid_high,
    output logic [ght_pkg::GUID_W-1:0]     out_guid_low,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ght_pkg::FIF_W-1:0]      cfg_data
);

    localparam int IW = ght_pkg::IDX_W;
    localparam int CW = ght_pkg::CNT_W;
    localparam int RW = $bits(ght_pkg::rec_t);
    localparam int GW = 2 * ght_pkg::GUID_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EX   = 3'd3;
    localparam logic [2:0] S_TOUT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // control state
    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                used_reg, used_next;
    logic [CW-1:0]                top_reg, top_next;
    logic [ght_pkg::FIF_W-1:0]    fif_reg, fif_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         hold_reg, hold_next;

    // request payload
    logic [2:0]                   cmd_reg, cmd_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [ght_pkg::GEN_W-1:0]    gen_reg, gen_next;
    logic [ght_pkg::TYPE_W-1:0]   ty_reg, ty_next;
    logic [ght_pkg::TYPE_W-1:0]   want_reg, want_next;
    logic [ght_pkg::GUID_W-1:0]   gh_reg, gh_next;
    logic [ght_pkg::GUID_W-1:0]   gl_reg, gl_next;
    logic [IW-1:0]                slot_reg, slot_next;
    logic                         fresh_reg, fresh_next;

    // presented result
    logic [2:0]                   st_reg, st_next;
    logic [IW-1:0]                oidx_reg, oidx_next;
    logic [ght_pkg::GEN_W-1:0]    ogen_reg, ogen_next;
    logic [ght_pkg::TYPE_W-1:0]   otype_reg, otype_next;
    logic [ght_pkg::GUID_W-1:0]   ogh_reg, ogh_next;
    logic [ght_pkg::GUID_W-1:0]   ogl_reg, ogl_next;
    logic                         olast_reg, olast_next;

    // freed slot result held until the next one is known
    logic [IW-1:0]                hidx_reg, hidx_next;
    logic [ght_pkg::GEN_W-1:0]    hgen_reg, hgen_next;
    logic [ght_pkg::TYPE_W-1:0]   htype_reg, htype_next;
    logic [GW-1:0]                hguid_reg, hguid_next;

    // memory ports
    logic                         rec_we, rec_re;
    ght_pkg::rec_t                rec_wdata;
    logic [RW-1:0]                rec_rdata;
    logic                         guid_we, guid_re;
    logic [GW-1:0]                guid_rdata;
    logic                         fs_we, fs_re;
    logic [IW-1:0]                fs_waddr, fs_raddr, fs_rdata;

    ght_pkg::rec_t                rec;
    logic                         in_rng, last_slot, do_adv, hdl_ok;

    ght_ram #(.WIDTH(RW), .DEPTH(ght_pkg::SLOTS)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (slot_reg),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (slot_reg),
        .rdata (rec_rdata)
    );

    ght_ram #(.WIDTH(GW), .DEPTH(ght_pkg::SLOTS)) u_guid_ram (
        .clk   (clk),
        .we    (guid_we),
        .waddr (slot_reg),
        .wdata ({gh_reg, gl_reg}),
        .re    (guid_re),
        .raddr (slot_reg),
        .rdata (guid_rdata)
    );

    ght_ram #(.WIDTH(IW), .DEPTH(ght_pkg::SLOTS)) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (slot_reg),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status         = st_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign out_type       = otype_reg;
    assign out_guid_high  = ogh_reg;
    assign out_guid_low   = ogl_reg;
    assign last           = olast_reg;

    // a never-used slot reads as its reset record
    assign rec       = fresh_reg ? ght_pkg::REC_RESET : ght_pkg::rec_t'(rec_rdata);
    assign in_rng    = ({1'b0, idx_reg} < used_reg);
    assign last_slot = (({1'b0, slot_reg} + 1'b1) == used_reg);
    assign fs_waddr  = top_reg[IW-1:0];
    assign fs_raddr  = IW'(top_reg - 1'b1);
    assign hdl_ok    = (gen_reg != '0) && in_rng && rec.live && (rec.kind == ty_reg)
                       && (rec.gen == gen_reg);

    function automatic logic [ght_pkg::CD_W-1:0] CD_W_EXT(input logic [ght_pkg::FIF_W-1:0] v);
        CD_W_EXT = {{(ght_pkg::CD_W - ght_pkg::FIF_W){1'b0}}, v};
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        top_next       = top_reg;
        fif_next       = fif_reg;
        out_valid_next = out_valid_reg;
        hold_next      = hold_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        gen_next       = gen_reg;
        ty_next        = ty_reg;
        want_next      = want_reg;
        gh_next        = gh_reg;
        gl_next        = gl_reg;
        slot_next      = slot_reg;
        fresh_next     = fresh_reg;
        st_next        = st_reg;
        oidx_next      = oidx_reg;
        ogen_next      = ogen_reg;
        otype_next     = otype_reg;
        ogh_next       = ogh_reg;
        ogl_next       = ogl_reg;
        olast_next     = olast_reg;
        hidx_next      = hidx_reg;
        hgen_next      = hgen_reg;
        htype_next     = htype_reg;
        hguid_next     = hguid_reg;
        rec_we         = 1'b0;
        rec_re         = 1'b0;
        rec_wdata      = rec;
        guid_we        = 1'b0;
        guid_re        = 1'b0;
        fs_we          = 1'b0;
        fs_re          = 1'b0;
        do_adv         = 1'b0;

        if (cfg_valid)
        begin
            fif_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    idx_next   = slot_index;
                    gen_next   = handle_generation;
                    ty_next    = type_code;
                    want_next  = expected_type;
                    gh_next    = guid_high;
                    gl_next    = guid_low;
                    fresh_next = 1'b0;
                    hold_next  = 1'b0;
                    // default result: everything zero, invalid, last
                    st_next    = ght_pkg::ST_INVALID;
                    oidx_next  = '0;
                    ogen_next  = '0;
                    otype_next = '0;
                    ogh_next   = '0;
                    ogl_next   = '0;
                    olast_next = 1'b1;
                    case (cmd)
                        ght_pkg::CMD_CREATE:
                        begin
                            if (top_reg != '0)
                            begin
                                fs_re      = 1'b1;
                                top_next   = top_reg - 1'b1;
                                state_next = S_POP;
                            end
                            else if (used_reg < CW'(ght_pkg::SLOTS))
                            begin
                                slot_next  = used_reg[IW-1:0];
                                used_next  = used_reg + 1'b1;
                                fresh_next = 1'b1;
                                state_next = S_RD;
                            end
                            else
                            begin
                                st_next        = ght_pkg::ST_FULL;
                                out_valid_next = 1'b1;
                                state_next     = S_OUT;
                            end
                        end
                        ght_pkg::CMD_RELEASE, ght_pkg::CMD_REUSE, ght_pkg::CMD_RESOLVE:
                        begin
                            slot_next  = slot_index;
                            state_next = S_RD;
                        end
                        ght_pkg::CMD_TICK:
                        begin
                            if (used_reg == '0)
                            begin
                                st_next        = ght_pkg::ST_NONE;
                                out_valid_next = 1'b1;
                                state_next     = S_OUT;
                            end
                            else
                            begin
                                slot_next  = '0;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                slot_next  = fs_rdata;
                state_next = S_RD;
            end
            S_RD:
            begin
                rec_re     = 1'b1;
                guid_re    = 1'b1;
                state_next = S_EX;
            end
            S_EX:
            begin
                case (cmd_reg)
                    ght_pkg::CMD_CREATE:
                    begin
                        rec_wdata.live = 1'b1;
                        rec_wdata.kind = ty_reg;
                        rec_wdata.gen  = (rec.gen == '0) ? 32'd1 : rec.gen;
                        rec_wdata.refs = 16'd1;
                        rec_wdata.cd   = ght_pkg::CD_DISARMED;
                        rec_we         = 1'b1;
                        guid_we        = 1'b1;
                        st_next        = ght_pkg::ST_OK;
                        oidx_next      = slot_reg;
                        ogen_next      = rec_wdata.gen;
                        otype_next     = ty_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    ght_pkg::CMD_RELEASE:
                    begin
                        if (hdl_ok && rec.refs == '0)
                        begin
                            st_next = ght_pkg::ST_ZERO_REF;
                        end
                        else if (hdl_ok)
                        begin
                            rec_wdata.refs = rec.refs - 1'b1;
                            if (rec_wdata.refs == '0)
                            begin
                                rec_wdata.cd = CD_W_EXT(fif_reg);
                            end
                            rec_we     = 1'b1;
                            st_next    = ght_pkg::ST_OK;
                            oidx_next  = idx_reg;
                            ogen_next  = gen_reg;
                            otype_next = ty_reg;
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    ght_pkg::CMD_REUSE:
                    begin
                        if (in_rng && rec.live && rec.gen != '0
                            && (ty_reg == '0 || rec.kind == ty_reg))
                        begin
                            if (rec.refs == ght_pkg::REF_MAX)
                            begin
                                st_next = ght_pkg::ST_SATURATED;
                            end
                            else
                            begin
                                rec_wdata.refs = rec.refs + 1'b1;
                                st_next        = ght_pkg::ST_OK;
                            end
                            rec_wdata.cd = ght_pkg::CD_DISARMED;
                            rec_we       = 1'b1;
                            oidx_next    = idx_reg;
                            ogen_next    = rec.gen;
                            otype_next   = rec.kind;
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    ght_pkg::CMD_RESOLVE:
                    begin
                        if (hdl_ok && (want_reg == '0 || rec.kind == want_reg))
                        begin
                            st_next    = ght_pkg::ST_OK;
                            oidx_next  = idx_reg;
                            ogen_next  = gen_reg;
                            otype_next = ty_reg;
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    default:
                    begin
                        // frame tick, one slot
                        if (!rec.live || rec.cd > 5'd15)
                        begin
                            do_adv = 1'b1;
                        end
                        else if (rec.cd > 5'd1)
                        begin
                            rec_wdata.cd = rec.cd - 1'b1;
                            rec_we       = 1'b1;
                            do_adv       = 1'b1;
                        end
                        else
                        begin
                            rec_wdata.live = 1'b0;
                            rec_wdata.kind = '0;
                            rec_wdata.gen  = rec.gen + 1'b1;
                            rec_wdata.refs = '0;
                            rec_wdata.cd   = ght_pkg::CD_DISARMED;
                            rec_we         = 1'b1;
                            if (top_reg < CW'(ght_pkg::SLOTS))
                            begin
                                fs_we    = 1'b1;
                                top_next = top_reg + 1'b1;
                            end
                            if (hold_reg)
                            begin
                                st_next        = ght_pkg::ST_FREED;
                                oidx_next      = hidx_reg;
                                ogen_next      = hgen_reg;
                                otype_next     = htype_reg;
                                ogh_next       = hguid_reg[GW-1:ght_pkg::GUID_W];
                                ogl_next       = hguid_reg[ght_pkg::GUID_W-1:0];
                                olast_next     = 1'b0;
                                out_valid_next = 1'b1;
                                state_next     = S_TOUT;
                            end
                            else
                            begin
                                do_adv = 1'b1;
                            end
                            hold_next  = 1'b1;
                            hidx_next  = slot_reg;
                            hgen_next  = rec.gen;
                            htype_next = rec.kind;
                            hguid_next = guid_rdata;
                        end
                    end
                endcase
            end
            S_TOUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    do_adv         = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next slot of a tick, or its closing result
        if (do_adv)
        begin
            if (!last_slot)
            begin
                slot_next  = slot_reg + 1'b1;
                state_next = S_RD;
            end
            else
            begin
                st_next        = hold_next ? ght_pkg::ST_FREED : ght_pkg::ST_NONE;
                oidx_next      = hold_next ? hidx_next : '0;
                ogen_next      = hold_next ? hgen_next : '0;
                otype_next     = hold_next ? htype_next : '0;
                ogh_next       = hold_next ? hguid_next[GW-1:ght_pkg::GUID_W] : '0;
                ogl_next       = hold_next ? hguid_next[ght_pkg::GUID_W-1:0] : '0;
                olast_next     = 1'b1;
                hold_next      = 1'b0;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            top_reg       <= '0;
            fif_reg       <= ght_pkg::FIF_RESET;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
            cmd_reg       <= '0;
            fresh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            top_reg       <= top_next;
            fif_reg       <= fif_next;
            out_valid_reg <= out_valid_next;
            hold_reg      <= hold_next;
            cmd_reg       <= cmd_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        gen_reg   <= gen_next;
        ty_reg    <= ty_next;
        want_reg  <= want_next;
        gh_reg    <= gh_next;
        gl_reg    <= gl_next;
        slot_reg  <= slot_next;
        st_reg    <= st_next;
        oidx_reg  <= oidx_next;
        ogen_reg  <= ogen_next;
        otype_reg <= otype_next;
        ogh_reg   <= ogh_next;
        ogl_reg   <= ogl_next;
        olast_reg <= olast_next;
        hidx_reg  <= hidx_next;
        hgen_reg  <= hgen_next;
        htype_reg <= htype_next;
        hguid_reg <= hguid_next;
    end

    // a request once taken keeps the input side stalled for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in work");

    // the free stack never holds more slots than were ever used
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= used_reg && used_reg <= CW'(ght_pkg::SLOTS))
        else $error("free stack or fill count out of bounds");

    // a result is shown only in a result state
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OUT || state_reg == S_TOUT))
        else $error("result valid outside a result state");

    // an early freed result always has a successor held back
    a_tout_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TOUT |-> hold_reg && !last)
        else $error("non-final freed result without a held successor");

endmodule
